// ===== sv/slope_limiter_factor_defines.svh =====
// assertion macros shared by the limiter rtl
`ifndef SLOPE_LIMITER_FACTOR_DEFINES_SVH
`define SLOPE_LIMITER_FACTOR_DEFINES_SVH

// same-cycle implication, sampled on clk, quiet during reset
`define SLF_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("slope limiter check failed");

// next-cycle implication, sampled on clk, quiet during reset
`define SLF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("slope limiter check failed");

`endif

// ===== sv/slf_pkg.sv =====
`default_nettype none

package slf_pkg;

    // value format
    localparam int VALUE_WIDTH  = 32;
    localparam int FRAC_BITS    = 16;

    // derived widths
    localparam int BETA_WIDTH   = 18;
    localparam int FACTOR_WIDTH = FRAC_BITS + 1;
    localparam int DIFF_WIDTH   = VALUE_WIDTH + 1;
    localparam int REM_WIDTH    = DIFF_WIDTH + 1;
    localparam int QUOT_WIDTH   = 2 * FRAC_BITS;
    localparam int RATIO_WIDTH  = QUOT_WIDTH + 1;
    localparam int PROD_WIDTH   = BETA_WIDTH + RATIO_WIDTH;
    localparam int HI_WIDTH     = PROD_WIDTH - FRAC_BITS;
    localparam int CNT_WIDTH    = $clog2(QUOT_WIDTH);

    typedef logic signed [VALUE_WIDTH-1:0] value_t;
    typedef logic [BETA_WIDTH-1:0]         beta_t;
    typedef logic [FACTOR_WIDTH-1:0]       factor_t;
    typedef logic [DIFF_WIDTH-1:0]         diff_t;
    typedef logic [REM_WIDTH-1:0]          rem_t;
    typedef logic [QUOT_WIDTH-1:0]         quot_t;
    typedef logic [RATIO_WIDTH-1:0]        ratio_t;
    typedef logic [PROD_WIDTH-1:0]         prod_t;
    typedef logic [HI_WIDTH-1:0]           hi_t;
    typedef logic [CNT_WIDTH-1:0]          cnt_t;

    // 1.0 in the unsigned factor formats, plus the saturated ratio and the last divider step
    localparam factor_t ONE        = factor_t'(1) << FRAC_BITS;
    localparam ratio_t  RATIO_ONE  = ratio_t'(1) << FRAC_BITS;
    localparam ratio_t  RATIO_CAP  = ratio_t'(1) << QUOT_WIDTH;
    localparam hi_t     HI_ONE     = hi_t'(1) << FRAC_BITS;
    localparam beta_t   BETA_RESET = beta_t'(1) << FRAC_BITS;
    localparam cnt_t    LAST_STEP  = cnt_t'(QUOT_WIDTH - 1);

    // divider status toward the sequencer
    typedef struct packed {
        logic done;
        logic saturated;
    } div_stat_t;

endpackage

`default_nettype wire

// ===== sv/slope_limiter_factor.sv =====
`default_nettype none

// Limiter factor for one cell and field: each request is one nodal value with the
// cell mean and neighbor bounds, and the request flagged last_node returns psi, the
// minimum of the node factors since the previous last node (1.0 if none limited).
// One request is taken at a time. A node inside the bounds, or one whose ratio is
// zero, goes through PREP, MAG, MULT and UPD; a node outside the bounds also goes
// through DIV, whose radix-2 divider finds the 32 quotient bits one a cycle or
// ends at its saturation check. The user must write beta through the cfg channel
// while no request is in flight (unenforced); it is used from the next request on.

`include "slope_limiter_factor_defines.svh"

module slope_limiter_factor (
    input  wire logic            clk,
    input  wire logic            rst_n,
    // input channel
    input  wire logic            in_valid,
    output logic                 in_stall,
    input  wire slf_pkg::value_t node_value,
    input  wire slf_pkg::value_t cell_mean,
    input  wire slf_pkg::value_t bound_high,
    input  wire slf_pkg::value_t bound_low,
    input  wire logic            last_node,
    // output channel
    output logic                 out_valid,
    input  wire logic            out_stall,
    output slf_pkg::factor_t     limiter_factor,
    // configuration
    input  wire logic            cfg_valid,
    output logic                 cfg_ready,
    input  wire slf_pkg::beta_t  beta
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_PREP = 6'b000010,
        S_MAG  = 6'b000100,
        S_DIV  = 6'b001000,
        S_MULT = 6'b010000,
        S_UPD  = 6'b100000
    } state_t;

    state_t            state_reg, state_next;
    slf_pkg::beta_t    beta_reg;
    slf_pkg::factor_t  running_reg, running_next;
    logic              out_valid_reg, out_valid_next;
    slf_pkg::factor_t  lim_reg, lim_next;

    slf_pkg::value_t   node_reg, mean_reg, bh_reg, bl_reg;
    logic              last_reg;
    slf_pkg::diff_t    num_reg, num_next;
    slf_pkg::diff_t    den_reg, den_next;
    logic              oor_reg, oor_next;
    slf_pkg::ratio_t   r_reg, r_next;
    slf_pkg::factor_t  a_reg, a_next;

    logic              gt, lt;
    slf_pkg::value_t   bound_sel;
    slf_pkg::diff_t    num_c, den_c;
    slf_pkg::diff_t    mag_n, mag_d;
    logic              zero_r;
    logic              div_start;
    slf_pkg::div_stat_t div_stat;
    slf_pkg::quot_t    quotient;
    slf_pkg::prod_t    prod;
    slf_pkg::hi_t      prod_hi;
    slf_pkg::ratio_t   beta_w, b_w, t_w;
    slf_pkg::factor_t  run_min;

    // bound test and signed differences
    always_comb
    begin
        gt        = node_reg > bh_reg;
        lt        = node_reg < bl_reg;
        bound_sel = gt ? bh_reg : bl_reg;
        num_c     = {bound_sel[slf_pkg::VALUE_WIDTH-1], bound_sel}
                  - {mean_reg[slf_pkg::VALUE_WIDTH-1], mean_reg};
        den_c     = {node_reg[slf_pkg::VALUE_WIDTH-1], node_reg}
                  - {mean_reg[slf_pkg::VALUE_WIDTH-1], mean_reg};
    end

    // magnitudes and the cases that force a zero ratio
    always_comb
    begin
        mag_n     = num_reg[slf_pkg::DIFF_WIDTH-1] ? (~num_reg + 1'b1) : num_reg;
        mag_d     = den_reg[slf_pkg::DIFF_WIDTH-1] ? (~den_reg + 1'b1) : den_reg;
        zero_r    = (num_reg == '0)
                  || (num_reg[slf_pkg::DIFF_WIDTH-1] != den_reg[slf_pkg::DIFF_WIDTH-1]);
        div_start = (state_reg == S_MAG) && oor_reg && !zero_r;
    end

    slf_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (mag_n),
        .divisor  (mag_d),
        .stat     (div_stat),
        .quotient (quotient)
    );

    // beta * r, clamped to 1.0
    always_comb
    begin
        prod    = {{slf_pkg::RATIO_WIDTH{1'b0}}, beta_reg}
                * {{slf_pkg::BETA_WIDTH{1'b0}}, r_reg};
        prod_hi = prod[slf_pkg::PROD_WIDTH-1:slf_pkg::FRAC_BITS];
        a_next  = (prod_hi > slf_pkg::HI_ONE) ? slf_pkg::ONE
                                               : prod_hi[slf_pkg::FACTOR_WIDTH-1:0];
    end

    // node factor and running minimum
    always_comb
    begin
        beta_w  = slf_pkg::ratio_t'(beta_reg);
        b_w     = (r_reg < beta_w) ? r_reg : beta_w;
        t_w     = (slf_pkg::ratio_t'(a_reg) > b_w) ? slf_pkg::ratio_t'(a_reg) : b_w;
        run_min = (t_w < slf_pkg::ratio_t'(running_reg))
                ? t_w[slf_pkg::FACTOR_WIDTH-1:0] : running_reg;
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        running_next   = running_reg;
        out_valid_next = out_valid_reg;
        lim_next       = lim_reg;
        num_next       = num_reg;
        den_next       = den_reg;
        oor_next       = oor_reg;
        r_next         = r_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                num_next   = num_c;
                den_next   = den_c;
                oor_next   = gt || lt;
                state_next = S_MAG;
            end
            S_MAG:
            begin
                if (!oor_reg)
                begin
                    r_next     = slf_pkg::RATIO_ONE;
                    state_next = S_MULT;
                end
                else if (zero_r)
                begin
                    r_next     = '0;
                    state_next = S_MULT;
                end
                else
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_stat.done)
                begin
                    r_next     = div_stat.saturated ? slf_pkg::RATIO_CAP
                                                    : {1'b0, quotient};
                    state_next = S_MULT;
                end
            end
            S_MULT:
            begin
                state_next = S_UPD;
            end
            S_UPD:
            begin
                if (!last_reg)
                begin
                    running_next = run_min;
                    state_next   = S_IDLE;
                end
                else if (!out_valid_reg || !out_stall)
                begin
                    lim_next       = run_min;
                    out_valid_next = 1'b1;
                    running_next   = slf_pkg::ONE;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            beta_reg      <= slf_pkg::BETA_RESET;
            running_reg   <= slf_pkg::ONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            running_reg   <= running_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                beta_reg <= beta;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
        begin
            node_reg <= node_value;
            mean_reg <= cell_mean;
            bh_reg   <= bound_high;
            bl_reg   <= bound_low;
            last_reg <= last_node;
        end
        num_reg <= num_next;
        den_reg <= den_next;
        oor_reg <= oor_next;
        r_reg   <= r_next;
        a_reg   <= a_next;
        lim_reg <= lim_next;
    end

    assign in_stall       = (state_reg != S_IDLE);
    assign out_valid      = out_valid_reg;
    assign limiter_factor = lim_reg;
    assign cfg_ready      = 1'b1;

    // checks
    `SLF_ASSERT_NOW(a_running_le_one, 1'b1, running_reg <= slf_pkg::ONE)
    `SLF_ASSERT_NOW(a_result_le_one, out_valid_reg, lim_reg <= slf_pkg::ONE)
    `SLF_ASSERT_NEXT(a_accept_to_prep, in_valid && !in_stall, state_reg == S_PREP)
    `SLF_ASSERT_NOW(a_div_done_in_div, div_stat.done, state_reg == S_DIV)

endmodule

`default_nettype wire

// ===== sv/slf_divider.sv =====
`default_nettype none

module slf_divider (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire slf_pkg::diff_t    dividend,
    input  wire slf_pkg::diff_t    divisor,
    output slf_pkg::div_stat_t     stat,
    output slf_pkg::quot_t         quotient
);

    typedef enum logic [2:0] {
        D_IDLE  = 3'b001,
        D_CHECK = 3'b010,
        D_STEP  = 3'b100
    } dstate_t;

    dstate_t        state_reg, state_next;
    logic           done_reg, done_next;
    logic           sat_reg, sat_next;
    slf_pkg::cnt_t  cnt_reg, cnt_next;
    slf_pkg::rem_t  rem_reg, rem_next;
    slf_pkg::quot_t dvd_reg, dvd_next;
    slf_pkg::diff_t dvs_reg, dvs_next;

    slf_pkg::rem_t  rem_sh;
    slf_pkg::rem_t  rem_sel;
    logic [slf_pkg::REM_WIDTH:0] trial;
    logic           ge;

    // shared subtractor: saturation check, then one quotient bit a cycle
    always_comb
    begin
        rem_sh  = {rem_reg[slf_pkg::REM_WIDTH-2:0], dvd_reg[slf_pkg::QUOT_WIDTH-1]};
        rem_sel = (state_reg == D_CHECK) ? rem_reg : rem_sh;
        trial   = {1'b0, rem_sel} - {2'b00, dvs_reg};
        ge      = ~trial[slf_pkg::REM_WIDTH];
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        sat_next   = sat_reg;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        dvd_next   = dvd_reg;
        dvs_next   = dvs_reg;
        case (state_reg)
            D_IDLE:
            begin
                if (start)
                begin
                    rem_next   = {1'b0, dividend >> slf_pkg::FRAC_BITS};
                    dvd_next   = {dividend[slf_pkg::FRAC_BITS-1:0],
                                  {slf_pkg::FRAC_BITS{1'b0}}};
                    dvs_next   = divisor;
                    state_next = D_CHECK;
                end
            end
            D_CHECK:
            begin
                // integer part of the ratio would not fit the 16 integer bits of the Q16.16 quotient
                if (ge)
                begin
                    sat_next   = 1'b1;
                    done_next  = 1'b1;
                    state_next = D_IDLE;
                end
                else
                begin
                    sat_next   = 1'b0;
                    cnt_next   = '0;
                    state_next = D_STEP;
                end
            end
            D_STEP:
            begin
                rem_next = ge ? trial[slf_pkg::REM_WIDTH-1:0] : rem_sh;
                dvd_next = {dvd_reg[slf_pkg::QUOT_WIDTH-2:0], ge};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == slf_pkg::LAST_STEP)
                begin
                    done_next  = 1'b1;
                    state_next = D_IDLE;
                end
            end
            default:
            begin
                state_next = D_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            done_reg  <= 1'b0;
            sat_reg   <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            sat_reg   <= sat_next;
            cnt_reg   <= cnt_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
    end

    assign stat.done      = done_reg;
    assign stat.saturated = sat_reg;
    assign quotient       = dvd_reg;

endmodule

`default_nettype wire
